>>> design/gpled_pkg.sv
`timescale 1ns / 1ps

package gpled_pkg;

  // Pulse steps between the dark and bright ends of the link-down pulse
  localparam int PULSE_STEPS_DEF = 20;

  // Axis extremes
  localparam logic signed [7:0] AXIS_POS = 8'sd127;
  localparam logic signed [7:0] AXIS_NEG = -8'sd127;
  localparam logic signed [7:0] AXIS_MID = 8'sd0;

  // Register reset levels
  localparam logic [7:0] IDLE_RESET  = 8'd10;
  localparam logic [7:0] PRESS_RESET = 8'd80;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_IDLE  = 1'b0;
  localparam logic REG_PRESS = 1'b1;

  // blue = floor(level * 255 / 200) as (level * 255 * 5243) >> 20
  localparam logic [20:0] BLUE_MUL   = 21'd1336965;
  localparam int          BLUE_SHIFT = 20;

  // Pin positions within pin_levels (active low)
  localparam int PIN_UP    = 0;
  localparam int PIN_DOWN  = 1;
  localparam int PIN_LEFT  = 2;
  localparam int PIN_RIGHT = 3;

  typedef struct packed {
    logic              send_report;
    logic signed [7:0] x_axis;
    logic signed [7:0] y_axis;
    logic        [3:0] button_mask;
  } report_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_t;

endpackage

>>> design/gpled_poll_if.sv
`timescale 1ns / 1ps

interface gpled_poll_if;
  logic       valid;
  logic       ready;
  logic [7:0] pin_levels;
  logic       link_up;

  modport source (output valid, output pin_levels, output link_up, input ready);
  modport sink   (input valid, input pin_levels, input link_up, output ready);
endinterface

>>> design/gpled_report_if.sv
`timescale 1ns / 1ps

interface gpled_report_if;
  logic              valid;
  logic              ready;
  logic              send_report;
  logic signed [7:0] x_axis;
  logic signed [7:0] y_axis;
  logic        [3:0] button_mask;
  logic        [7:0] led_red;
  logic        [7:0] led_green;
  logic        [7:0] led_blue;

  modport source (output valid, output send_report, output x_axis, output y_axis,
                  output button_mask, output led_red, output led_green,
                  output led_blue, input ready);
  modport sink   (input valid, input send_report, input x_axis, input y_axis,
                  input button_mask, input led_red, input led_green,
                  input led_blue, output ready);
endinterface

>>> design/gpled_report.sv
`timescale 1ns / 1ps

module gpled_report import gpled_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [7:0] pin_levels,
  input  logic       link_up,
  output report_t    rpt
);

  logic [7:0]        pressed;
  logic signed [7:0] x_val;
  logic signed [7:0] y_val;
  logic [3:0]        btn;
  logic              differs;
  logic signed [7:0] sent_x;
  logic signed [7:0] sent_y;
  logic [3:0]        sent_buttons;

  // Decode the pins: up beats down, left beats right
  always_comb begin
    pressed = ~pin_levels;
    if (pressed[PIN_UP]) begin
      y_val = AXIS_NEG;
    end else if (pressed[PIN_DOWN]) begin
      y_val = AXIS_POS;
    end else begin
      y_val = AXIS_MID;
    end
    if (pressed[PIN_LEFT]) begin
      x_val = AXIS_NEG;
    end else if (pressed[PIN_RIGHT]) begin
      x_val = AXIS_POS;
    end else begin
      x_val = AXIS_MID;
    end
    btn     = pressed[7:4];
    differs = (x_val != sent_x) || (y_val != sent_y) || (btn != sent_buttons);
  end

  assign rpt.send_report = link_up && differs;
  assign rpt.x_axis      = x_val;
  assign rpt.y_axis      = y_val;
  assign rpt.button_mask = btn;

  // Remember the last report sent
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_x       <= AXIS_MID;
      sent_y       <= AXIS_MID;
      sent_buttons <= 4'd0;
    end else if (adv && link_up && differs) begin
      sent_x       <= x_val;
      sent_y       <= y_val;
      sent_buttons <= btn;
    end
  end

  a_sent_holds_link_down: assert property (@(posedge clk) disable iff (rst)
    (adv && !link_up) |=> ($stable(sent_x) && $stable(sent_y) && $stable(sent_buttons)))
    else $error("stored report changed while link down");

endmodule

>>> design/gpled_led.sv
`timescale 1ns / 1ps

module gpled_led import gpled_pkg::*; #(
  parameter int PULSE_STEPS = PULSE_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [7:0] pin_levels,
  input  logic       link_up,
  input  logic [7:0] idle_brightness,
  input  logic [7:0] press_brightness,
  output led_t       led
);

  localparam logic [5:0] STEPS = 6'(PULSE_STEPS);

  logic [7:0]  pressed;
  logic [4:0]  pulse_level;
  logic        pulse_rising;
  logic [4:0]  pulse_level_next;
  logic        pulse_rising_next;
  logic [5:0]  level_up;
  logic [25:0] blue_prod;
  logic [7:0]  p;

  // Pick the colour by priority
  always_comb begin
    pressed   = ~pin_levels;
    p         = press_brightness;
    blue_prod = 26'(pulse_level * BLUE_MUL);
    if (!link_up) begin
      led = '{red: 8'd0, green: 8'd0, blue: 8'(blue_prod[25:BLUE_SHIFT])};
    end else if (|pressed[3:0]) begin
      led = '{red: p, green: p, blue: p};
    end else if (pressed[4]) begin
      led = '{red: 8'd0, green: 8'd0, blue: p};
    end else if (pressed[5]) begin
      led = '{red: p, green: 8'd0, blue: 8'd0};
    end else if (pressed[6]) begin
      led = '{red: p, green: 8'd0, blue: p};
    end else if (pressed[7]) begin
      led = '{red: 8'd0, green: p, blue: 8'd0};
    end else begin
      led = '{red: idle_brightness, green: idle_brightness, blue: idle_brightness};
    end
  end

  // Bounce the pulse level between zero and the top step
  always_comb begin
    level_up          = {1'b0, pulse_level} + 6'd1;
    pulse_level_next  = pulse_level;
    pulse_rising_next = pulse_rising;
    if (pulse_rising) begin
      if (level_up >= STEPS) begin
        pulse_level_next  = STEPS[4:0];
        pulse_rising_next = 1'b0;
      end else begin
        pulse_level_next = level_up[4:0];
      end
    end else begin
      if (pulse_level <= 5'd1) begin
        pulse_level_next  = 5'd0;
        pulse_rising_next = 1'b1;
      end else begin
        pulse_level_next = pulse_level - 5'd1;
      end
    end
  end

  // Advance only on link-down ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_level  <= 5'd0;
      pulse_rising <= 1'b1;
    end else if (adv && !link_up) begin
      pulse_level  <= pulse_level_next;
      pulse_rising <= pulse_rising_next;
    end
  end

  a_pulse_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pulse_level} <= STEPS)
    else $error("pulse level above top step");

  a_pulse_holds_link_up: assert property (@(posedge clk) disable iff (rst)
    (adv && link_up) |=> ($stable(pulse_level) && $stable(pulse_rising)))
    else $error("pulse moved while link up");

endmodule

>>> design/gamepad_report_and_status_led.sv
`timescale 1ns / 1ps
// Path: an accepted poll word is held in the input register, then in the
//   result register, from which its report word can be taken.
// Throughput: one poll word per cycle while report.ready holds; both
//   stages advance together and the result register frees as it is taken.
// Reset (rst, synchronous): pipeline empty, stored report zero, pulse at
//   step 0 rising, idle_brightness 10, press_brightness 80.

module gamepad_report_and_status_led import gpled_pkg::*; #(
  parameter int PULSE_STEPS = PULSE_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  gpled_poll_if.sink            poll,
  gpled_report_if.source        report,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic       s1_valid;
  logic [7:0] s1_pins;
  logic       s1_link;
  logic       out_valid;
  report_t    out_rpt;
  led_t       out_led;
  report_t    rpt;
  led_t       led;
  logic       out_free;
  logic       s1_adv;
  logic [7:0] idle_brightness;
  logic [7:0] press_brightness;
  logic       cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_brightness  <= IDLE_RESET;
      press_brightness <= PRESS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IDLE:  idle_brightness  <= pwdata[7:0];
        REG_PRESS: press_brightness <= pwdata[7:0];
        default:   idle_brightness  <= idle_brightness;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IDLE:  prdata = {24'd0, idle_brightness};
      REG_PRESS: prdata = {24'd0, press_brightness};
      default:   prdata = 32'd0;
    endcase
  end

  // Handshake: result register frees when empty or taken
  assign out_free   = !out_valid || report.ready;
  assign s1_adv     = s1_valid && out_free;
  assign poll.ready = !s1_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_pins <= poll.pin_levels;
      s1_link <= poll.link_up;
    end
  end

  gpled_report u_report (
    .clk        (clk),
    .rst        (rst),
    .adv        (s1_adv),
    .pin_levels (s1_pins),
    .link_up    (s1_link),
    .rpt        (rpt)
  );

  gpled_led #(
    .PULSE_STEPS (PULSE_STEPS)
  ) u_led (
    .clk              (clk),
    .rst              (rst),
    .adv              (s1_adv),
    .pin_levels       (s1_pins),
    .link_up          (s1_link),
    .idle_brightness  (idle_brightness),
    .press_brightness (press_brightness),
    .led              (led)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rpt <= rpt;
      out_led <= led;
    end
  end

  assign report.valid       = out_valid;
  assign report.send_report = out_rpt.send_report;
  assign report.x_axis      = out_rpt.x_axis;
  assign report.y_axis      = out_rpt.y_axis;
  assign report.button_mask = out_rpt.button_mask;
  assign report.led_red     = out_led.red;
  assign report.led_green   = out_led.green;
  assign report.led_blue    = out_led.blue;

  a_no_send_link_down: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !s1_link) |=> !out_rpt.send_report)
    else $error("report flagged while link down");

  a_dark_red_link_down: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !s1_link) |=> (out_led.red == 8'd0 && out_led.green == 8'd0))
    else $error("pulse shows red or green");

endmodule
